// ===== design/dispi2c_pkg.sv =====
// ----------------------------------------------------------------------------
// dispi2c_pkg
// Shared types and constants for the display I2C write sequencer: item
// codes, register indexes, phase encoding and the structs between the parts.
// ----------------------------------------------------------------------------
package dispi2c_pkg;

    // default sizes
    localparam int WAIT_BITS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int WAIT_EXT_W      = 16;

    // input mode codes
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_COMMAND = 2'd1;
    localparam logic [1:0] MODE_DATA    = 2'd2;
    localparam logic [1:0] MODE_CURSOR  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_LONG_WAIT      = 2'd1;
    localparam logic [1:0] REG_SHORT_WAIT     = 2'd2;

    // register reset values
    localparam logic [7:0] DEV_ADDR_RST   = 8'h78;
    localparam logic [7:0] LONG_WAIT_RST  = 8'd5;
    localparam logic [7:0] SHORT_WAIT_RST = 8'd2;

    // byte constants of the display protocol
    localparam logic [7:0] CTRL_COMMAND  = 8'h00;
    localparam logic [7:0] CTRL_DATA     = 8'h40;
    localparam logic [7:0] PAGE_BASE     = 8'hB0;
    localparam logic [7:0] COL_HIGH_BASE = 8'h10;
    localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

    // bit and byte counting
    localparam logic [3:0] ACK_BIT          = 4'd8;
    localparam logic [1:0] LAST_BYTE        = 2'd2;
    localparam logic [1:0] LAST_CURSOR_STEP = 2'd2;

    // classified item kind
    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_COMMAND,
        KIND_DATA,
        KIND_CURSOR
    } kind_t;

    // bus phase of the back end
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START_A = 4'd1,
        PH_START_B = 4'd2,
        PH_START_C = 4'd3,
        PH_SETUP   = 4'd4,
        PH_HIGH    = 4'd5,
        PH_LOW     = 4'd6,
        PH_STOP_A  = 4'd7,
        PH_STOP_B  = 4'd8,
        PH_STOP_C  = 4'd9
    } phase_t;

    // classified item: control byte and up to three payload bytes
    typedef struct packed {
        kind_t      kind;
        logic [7:0] control;
        logic [7:0] pay0;
        logic [7:0] pay1;
        logic [7:0] pay2;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic busy_res;
        logic rejected;
    } result_t;

endpackage

// ===== design/display_i2c_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// display_i2c_write_sequencer
// Bit-banged I2C write sequencer for a display: command, data and cursor
// requests become start/address/control/payload/stop transactions, paced
// by tick items.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  input     push / full         mode, byte_value, page, column
//  result    pop / empty         clock_line, data_line, busy_res, rejected
//  config    cfg_write           cfg_index, cfg_data
//
//  One item per clock while the result queue has room; the phase machine in
//  the back end handles one item per cycle.
//  Each result is registered in the result queue as its item is taken.
//  Reset empties both queues, releases both lines and loads register defaults.
//  A stalled result queue holds the back end; the input queue then fills and
//  raises full.
// ----------------------------------------------------------------------------
module display_i2c_write_sequencer #(
    parameter int WAIT_BITS   = dispi2c_pkg::WAIT_BITS_DEF,
    parameter int QUEUE_DEPTH = dispi2c_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] mode,
    input  logic [7:0] byte_value,
    input  logic [2:0] page,
    input  logic [6:0] column,
    output logic       empty,
    input  logic       pop,
    output logic       clock_line,
    output logic       data_line,
    output logic       busy_res,
    output logic       rejected,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    import dispi2c_pkg::*;

    cmd_t    front_cmd;
    cmd_t    queued_cmd;
    logic    cmd_empty;
    logic    cmd_take;
    result_t eng_res;
    result_t out_res;
    logic    res_full;
    logic    res_push;

    // classification
    dispi2c_front u_front (
        .mode       (mode),
        .byte_value (byte_value),
        .page       (page),
        .column     (column),
        .cmd        (front_cmd)
    );

    // queue between front and back end
    dispi2c_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_cmd),
        .full  (full),
        .pop   (cmd_take),
        .dout  (queued_cmd),
        .empty (cmd_empty)
    );

    // bus sequencer
    dispi2c_engine #(
        .WAIT_BITS (WAIT_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (queued_cmd),
        .cmd_valid (!cmd_empty),
        .cmd_take  (cmd_take),
        .res_room  (!res_full),
        .res       (eng_res),
        .res_push  (res_push)
    );

    // result queue
    dispi2c_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (eng_res),
        .full  (res_full),
        .pop   (pop),
        .dout  (out_res),
        .empty (empty)
    );

    assign clock_line = out_res.clock_line;
    assign data_line  = out_res.data_line;
    assign busy_res   = out_res.busy_res;
    assign rejected   = out_res.rejected;

endmodule

// ===== design/dispi2c_fifo.sv =====
// ----------------------------------------------------------------------------
// dispi2c_fifo
// Small first-word-fall-through queue, DEPTH entries (2 or more), used
// between the front and the back end and in front of the result ports.
// ----------------------------------------------------------------------------
module dispi2c_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // handshake qualification
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = store_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== design/dispi2c_front.sv =====
// ----------------------------------------------------------------------------
// dispi2c_front
// Classifies an incoming item and builds the bytes that its transactions
// will carry: control byte and the one or three payload bytes.
// ----------------------------------------------------------------------------
module dispi2c_front (
    input  logic [1:0]          mode,
    input  logic [7:0]          byte_value,
    input  logic [2:0]          page,
    input  logic [6:0]          column,
    output dispi2c_pkg::cmd_t   cmd
);

    import dispi2c_pkg::*;

    // mode decode and payload build
    always_comb
    begin
        cmd.kind    = KIND_TICK;
        cmd.control = CTRL_COMMAND;
        cmd.pay0    = byte_value;
        cmd.pay1    = byte_value;
        cmd.pay2    = byte_value;
        unique case (mode)
            MODE_TICK:
            begin
                cmd.kind = KIND_TICK;
            end
            MODE_COMMAND:
            begin
                cmd.kind = KIND_COMMAND;
            end
            MODE_DATA:
            begin
                cmd.kind    = KIND_DATA;
                cmd.control = CTRL_DATA;
            end
            MODE_CURSOR:
            begin
                cmd.kind = KIND_CURSOR;
                cmd.pay0 = PAGE_BASE + {5'b0, page};
                cmd.pay1 = COL_HIGH_BASE + {5'b0, column[6:4]};
                cmd.pay2 = {1'b0, column} & NIBBLE_MASK;
            end
            default:
            begin
                cmd.kind = KIND_TICK;
            end
        endcase
    end

endmodule

// ===== design/dispi2c_engine.sv =====
// ----------------------------------------------------------------------------
// dispi2c_engine
// Back end: runs the bus phase machine one item per cycle while results have
// room, holds the configuration registers and gives one result per item taken.
// ----------------------------------------------------------------------------
module dispi2c_engine #(
    parameter int WAIT_BITS = dispi2c_pkg::WAIT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [1:0]             cfg_index,
    input  logic [7:0]             cfg_data,
    input  dispi2c_pkg::cmd_t      cmd,
    input  logic                   cmd_valid,
    output logic                   cmd_take,
    input  logic                   res_room,
    output dispi2c_pkg::result_t   res,
    output logic                   res_push
);

    import dispi2c_pkg::*;

    // configuration
    logic [7:0] dev_addr_reg;
    logic [7:0] long_wait_reg;
    logic [7:0] short_wait_reg;

    // sequencer state
    phase_t               phase_reg, phase_next;
    logic                 clock_reg, clock_next;
    logic                 data_reg, data_next;
    logic [WAIT_BITS-1:0] wait_reg, wait_next;
    logic [3:0]           bit_reg, bit_next;
    logic [1:0]           byte_reg, byte_next;
    logic [1:0]           cstep_reg, cstep_next;
    logic                 cursor_reg, cursor_next;
    logic [7:0]           shift_reg, shift_next;
    logic [7:0]           control_reg, control_next;
    logic [7:0]           pay0_reg, pay0_next;
    logic [7:0]           pay1_reg, pay1_next;
    logic [7:0]           pay2_reg, pay2_next;

    logic                 fire;
    logic                 is_tick;
    logic                 start_req;
    logic                 reject;
    logic                 step;
    logic                 dec;
    logic                 enter;
    logic [7:0]           payload;
    logic [WAIT_BITS-1:0] long_w;
    logic [WAIT_BITS-1:0] short_w;
    logic [WAIT_EXT_W-1:0] long_ext;
    logic [WAIT_EXT_W-1:0] short_ext;

    // item events
    assign fire      = cmd_valid && res_room;
    assign cmd_take  = fire;
    assign res_push  = fire;
    assign is_tick   = (cmd.kind == KIND_TICK);
    assign start_req = fire && !is_tick && (phase_reg == PH_IDLE);
    assign reject    = fire && !is_tick && (phase_reg != PH_IDLE);
    assign step      = fire && is_tick && (phase_reg != PH_IDLE)
                       && (wait_reg <= WAIT_BITS'(1));
    assign dec       = fire && is_tick && (phase_reg != PH_IDLE)
                       && (wait_reg > WAIT_BITS'(1));
    assign enter     = start_req || (step && (phase_next != PH_IDLE));

    // waits taken modulo the counter width
    assign long_ext  = {{(WAIT_EXT_W - 8){1'b0}}, long_wait_reg};
    assign short_ext = {{(WAIT_EXT_W - 8){1'b0}}, short_wait_reg};
    assign long_w    = long_ext[WAIT_BITS-1:0];
    assign short_w   = short_ext[WAIT_BITS-1:0];

    // payload byte of the current transaction
    always_comb
    begin
        case (cstep_reg)
            2'd0:    payload = pay0_reg;
            2'd1:    payload = pay1_reg;
            default: payload = pay2_reg;
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (start_req)
        begin
            phase_next = PH_START_A;
        end
        else if (step)
        begin
            unique case (phase_reg)
                PH_START_A: phase_next = PH_START_B;
                PH_START_B: phase_next = PH_START_C;
                PH_START_C: phase_next = PH_SETUP;
                PH_SETUP:   phase_next = PH_HIGH;
                PH_HIGH:    phase_next = PH_LOW;
                PH_LOW:
                begin
                    if (bit_reg < ACK_BIT || byte_reg < LAST_BYTE)
                    begin
                        phase_next = PH_SETUP;
                    end
                    else
                    begin
                        phase_next = PH_STOP_A;
                    end
                end
                PH_STOP_A:  phase_next = PH_STOP_B;
                PH_STOP_B:  phase_next = PH_STOP_C;
                PH_STOP_C:
                begin
                    if (cursor_reg && cstep_reg < LAST_CURSOR_STEP)
                    begin
                        phase_next = PH_START_A;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:    phase_next = PH_IDLE;
            endcase
        end
    end

    // counters, shifter and line levels
    always_comb
    begin
        clock_next   = clock_reg;
        data_next    = data_reg;
        wait_next    = wait_reg;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        cstep_next   = cstep_reg;
        cursor_next  = cursor_reg;
        shift_next   = shift_reg;
        control_next = control_reg;
        pay0_next    = pay0_reg;
        pay1_next    = pay1_reg;
        pay2_next    = pay2_reg;

        // capture a new request
        if (start_req)
        begin
            cstep_next   = 2'd0;
            cursor_next  = (cmd.kind == KIND_CURSOR);
            control_next = cmd.control;
            pay0_next    = cmd.pay0;
            pay1_next    = cmd.pay1;
            pay2_next    = cmd.pay2;
        end

        // bookkeeping on leaving a phase
        if (step)
        begin
            case (phase_reg)
                PH_START_C:
                begin
                    byte_next  = 2'd0;
                    bit_next   = 4'd0;
                    shift_next = dev_addr_reg;
                end
                PH_LOW:
                begin
                    if (bit_reg < ACK_BIT)
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        bit_next   = bit_reg + 1'b1;
                    end
                    else if (byte_reg < LAST_BYTE)
                    begin
                        byte_next  = byte_reg + 1'b1;
                        shift_next = (byte_reg == 2'd0) ? control_reg : payload;
                        bit_next   = 4'd0;
                    end
                end
                PH_STOP_C:
                begin
                    if (cursor_reg && cstep_reg < LAST_CURSOR_STEP)
                    begin
                        cstep_next = cstep_reg + 1'b1;
                    end
                    else
                    begin
                        cursor_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // wait counter
        if (dec)
        begin
            wait_next = wait_reg - 1'b1;
        end
        else if (step)
        begin
            wait_next = '0;
        end

        // levels and wait of the phase being entered
        if (enter)
        begin
            case (phase_next)
                PH_START_A:
                begin
                    clock_next = 1'b1;
                    data_next  = 1'b1;
                    wait_next  = long_w;
                end
                PH_START_B:
                begin
                    data_next = 1'b0;
                    wait_next = long_w;
                end
                PH_START_C:
                begin
                    clock_next = 1'b0;
                    wait_next  = long_w;
                end
                PH_SETUP:
                begin
                    data_next = (bit_next >= ACK_BIT) ? 1'b1 : shift_next[7];
                    wait_next = short_w;
                end
                PH_HIGH:
                begin
                    clock_next = 1'b1;
                    wait_next  = long_w;
                end
                PH_LOW:
                begin
                    clock_next = 1'b0;
                    wait_next  = (bit_next >= ACK_BIT) ? '0 : short_w;
                end
                PH_STOP_A:
                begin
                    data_next = 1'b0;
                    wait_next = long_w;
                end
                PH_STOP_B:
                begin
                    clock_next = 1'b1;
                    wait_next  = long_w;
                end
                PH_STOP_C:
                begin
                    data_next = 1'b1;
                    wait_next = long_w;
                end
                default:
                begin
                    wait_next = '0;
                end
            endcase
        end
    end

    // result of this item
    assign res.clock_line = clock_next;
    assign res.data_line  = data_next;
    assign res.busy_res   = (phase_next != PH_IDLE);
    assign res.rejected   = reject;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            clock_reg  <= 1'b1;
            data_reg   <= 1'b1;
            wait_reg   <= '0;
            bit_reg    <= '0;
            byte_reg   <= '0;
            cstep_reg  <= '0;
            cursor_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            clock_reg  <= clock_next;
            data_reg   <= data_next;
            wait_reg   <= wait_next;
            bit_reg    <= bit_next;
            byte_reg   <= byte_next;
            cstep_reg  <= cstep_next;
            cursor_reg <= cursor_next;
        end
    end

    // byte holding registers
    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        control_reg <= control_next;
        pay0_reg    <= pay0_next;
        pay1_reg    <= pay1_next;
        pay2_reg    <= pay2_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg   <= DEV_ADDR_RST;
            long_wait_reg  <= LONG_WAIT_RST;
            short_wait_reg <= SHORT_WAIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEVICE_ADDRESS: dev_addr_reg   <= cfg_data;
                REG_LONG_WAIT:      long_wait_reg  <= cfg_data;
                REG_SHORT_WAIT:     short_wait_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== design/dispi2c_checker.sv =====
// ----------------------------------------------------------------------------
// dispi2c_checker
// Port-level checks for the display I2C write sequencer, bound to the top.
// ----------------------------------------------------------------------------
module dispi2c_checker (
    input logic clk,
    input logic rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input logic clock_line,
    input logic data_line,
    input logic busy_res,
    input logic rejected
);

    // a dropped request only happens inside a running sequence
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rejected |-> busy_res)
        else $error("rejected result without busy");

    // both lines are released whenever the sequencer is idle
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !busy_res |-> clock_line && data_line)
        else $error("idle result with a line held low");

    // input backs up only behind waiting results
    a_full_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input full while no result waits");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable({clock_line, data_line, busy_res, rejected}))
        else $error("waiting result changed");

endmodule

bind display_i2c_write_sequencer dispi2c_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .clock_line (clock_line),
    .data_line  (data_line),
    .busy_res   (busy_res),
    .rejected   (rejected)
);
